// ===== rtl/core/eight_bit_risc_core_unit_defines.svh =====
// ----------------------------------------------------------------------------
// eight_bit_risc_core_unit assertion macros
// Clocked, reset-qualified property wrappers for the core's checker.
// ----------------------------------------------------------------------------
`ifndef EIGHT_BIT_RISC_CORE_UNIT_DEFINES_SVH
`define EIGHT_BIT_RISC_CORE_UNIT_DEFINES_SVH

// base form: property sampled on clk, disabled while arst_n is low
`define EBRC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// same-cycle implication
`define EBRC_ASSERT_IMPLIES(label, ante, cons, msg) \
	`EBRC_ASSERT(label, (ante) |-> (cons), msg)

// next-cycle implication
`define EBRC_ASSERT_NEXT(label, ante, cons, msg) \
	`EBRC_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== rtl/core/ebrc_pkg.sv =====
// ----------------------------------------------------------------------------
// ebrc_pkg
// Shared constants, codes and port structs of the 8-bit RISC core.
// ----------------------------------------------------------------------------
package ebrc_pkg;

	localparam int unsigned DATA_DEPTH_DEF = 256;
	localparam int unsigned REG_COUNT      = 16;
	localparam int unsigned RIDX_W         = $clog2(REG_COUNT);
	localparam int unsigned NUM_CNT        = 6;
	localparam int unsigned CIDX_W         = $clog2(NUM_CNT);

	typedef logic [2:0] op_t;
	localparam op_t OP_EXEC   = 3'd0;
	localparam op_t OP_WR_REG = 3'd1;
	localparam op_t OP_WR_MEM = 3'd2;
	localparam op_t OP_RD_MEM = 3'd3;
	localparam op_t OP_RD_CNT = 3'd4;
	localparam op_t OP_RD_REG = 3'd5;

	typedef logic [3:0] opc_t;
	localparam opc_t OPC_ADD   = 4'd0;
	localparam opc_t OPC_SUB   = 4'd1;
	localparam opc_t OPC_MUL   = 4'd2;
	localparam opc_t OPC_INC   = 4'd3;
	localparam opc_t OPC_AND   = 4'd4;
	localparam opc_t OPC_OR    = 4'd5;
	localparam opc_t OPC_NOT   = 4'd6;
	localparam opc_t OPC_XOR   = 4'd7;
	localparam opc_t OPC_LOAD  = 4'd8;
	localparam opc_t OPC_STORE = 4'd9;
	localparam opc_t OPC_JMP   = 4'd10;
	localparam opc_t OPC_BEQZ  = 4'd11;
	localparam opc_t OPC_HALT  = 4'd15;

	typedef logic [CIDX_W-1:0] cidx_t;
	localparam cidx_t CNT_TOTAL = 3'd0;
	localparam cidx_t CNT_ARITH = 3'd1;
	localparam cidx_t CNT_LOGIC = 3'd2;
	localparam cidx_t CNT_DATA  = 3'd3;
	localparam cidx_t CNT_CTRL  = 3'd4;
	localparam cidx_t CNT_HALT  = 3'd5;

	typedef struct packed {
		logic              en;
		logic [RIDX_W-1:0] addr_a;
		logic [RIDX_W-1:0] addr_b;
		logic [RIDX_W-1:0] addr_c;
	} rf_rd_t;

	typedef struct packed {
		logic              en;
		logic [RIDX_W-1:0] addr;
		logic [7:0]        data;
	} rf_wr_t;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
	} rf_data_t;

endpackage

// ===== rtl/core/ebrc_regfile.sv =====
// ----------------------------------------------------------------------------
// ebrc_regfile
// Register file, one write and three registered reads with write bypass;
// two banks, each written in step, serve the read ports.
// ----------------------------------------------------------------------------
module ebrc_regfile import ebrc_pkg::*; (
	input  logic     clk,
	input  rf_rd_t   rd,
	input  rf_wr_t   wr,
	output rf_data_t q
);

	logic [7:0] bank_ab [REG_COUNT];
	logic [7:0] bank_c  [REG_COUNT];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			bank_ab[wr.addr] <= wr.data;
			bank_c[wr.addr]  <= wr.data;
		end
		if (rd.en) begin
			q.a <= (wr.en && wr.addr == rd.addr_a) ? wr.data : bank_ab[rd.addr_a];
			q.b <= (wr.en && wr.addr == rd.addr_b) ? wr.data : bank_ab[rd.addr_b];
			q.c <= (wr.en && wr.addr == rd.addr_c) ? wr.data : bank_c[rd.addr_c];
		end
	end

endmodule

// ===== rtl/core/eight_bit_risc_core_unit.sv =====
// ----------------------------------------------------------------------------
// eight_bit_risc_core_unit
// Path: a transaction is registered at the input, then its result in the output register.
// Throughput: one transaction per cycle unless out_ready stalls; a LOAD holds
//   back new input until its data-memory read goes to the register file.
// Reset: arst_n clears PC, halt flag, class counters and stage valids;
//   register file and data memory hold no reset value.
// ----------------------------------------------------------------------------
module eight_bit_risc_core_unit import ebrc_pkg::*; #(
	parameter int unsigned DATA_DEPTH = DATA_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [15:0] instr,
	input  logic [7:0]  addr,
	input  logic [3:0]  index,
	input  logic [7:0]  data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] next_pc,
	output logic        halted,
	output logic        executed,
	output logic [31:0] read_data
);

	localparam int unsigned AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

	typedef logic [AW-1:0] mod_tbl_t [256];

	function automatic mod_tbl_t build_mod_tbl();
		mod_tbl_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = AW'(i % DATA_DEPTH);
		end
		return t;
	endfunction

	localparam mod_tbl_t MOD_TBL = build_mod_tbl();

	logic              valid_s1;
	op_t               op_s1;
	logic [15:0]       instr_s1;
	logic [7:0]        addr_s1;
	logic [3:0]        index_s1;
	logic [7:0]        data_s1;

	logic              valid_s2;
	logic [15:0]       next_pc_s2;
	logic              halted_s2;
	logic              executed_s2;
	logic [31:0]       rdata_s2;
	logic              rmem_s2;
	logic [RIDX_W-1:0] rd_s2;
	logic [7:0]        mem_rd_s2;

	logic [15:0]       pc_q;
	logic              halt_q;
	logic              wb_pend_q;
	logic [31:0]       cnt_q [NUM_CNT];

	logic [7:0]        dmem [DATA_DEPTH];

	rf_rd_t            rf_rd;
	rf_wr_t            rf_wr;
	rf_data_t          rf_q;

	logic              in_fire;
	logic              s1_adv;
	logic              exec_s1;
	logic              load_s1;
	opc_t              opc;
	logic [7:0]        alu_res;
	logic              alu_wr;
	logic [7:0]        sum_ab;
	logic [AW-1:0]     mem_addr;
	logic              mem_we;
	logic              mem_re;
	logic [7:0]        mem_wdata;
	logic [15:0]       pc_plus2;
	logic [7:0]        br_off;
	logic [15:0]       br_target;
	logic [15:0]       npc;
	logic [15:0]       pc_new;
	logic              halt_new;
	logic [31:0]       rdata;
	logic [NUM_CNT-1:0] bump;

	assign in_fire  = in_valid && in_ready;
	assign s1_adv   = valid_s1 && (!valid_s2 || out_ready);
	assign opc      = instr_s1[15:12];
	assign exec_s1  = (op_s1 == OP_EXEC) && !halt_q;
	assign load_s1  = valid_s1 && exec_s1 && (opc == OPC_LOAD);
	assign in_ready = (!valid_s1 || s1_adv) && !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1    <= op;
			instr_s1 <= instr;
			addr_s1  <= addr;
			index_s1 <= index;
			data_s1  <= data;
		end
	end

	always_comb begin
		rf_rd.en     = in_fire;
		rf_rd.addr_a = (op == OP_RD_REG) ? index : instr[7:4];
		rf_rd.addr_b = instr[3:0];
		rf_rd.addr_c = instr[11:8];
	end

	ebrc_regfile u_regfile (
		.clk (clk),
		.rd  (rf_rd),
		.wr  (rf_wr),
		.q   (rf_q)
	);

	always_comb begin
		alu_res = 8'd0;
		alu_wr  = 1'b1;
		unique case (opc)
			OPC_ADD: alu_res = rf_q.a + rf_q.b;
			OPC_SUB: alu_res = rf_q.a - rf_q.b;
			OPC_MUL: alu_res = 8'(rf_q.a * rf_q.b);
			OPC_INC: alu_res = rf_q.c + 8'd1;
			OPC_AND: alu_res = rf_q.a & rf_q.b;
			OPC_OR:  alu_res = rf_q.a | rf_q.b;
			OPC_NOT: alu_res = ~rf_q.a;
			OPC_XOR: alu_res = rf_q.a ^ rf_q.b;
			default: alu_wr  = 1'b0;
		endcase
	end

	always_comb begin
		bump            = '0;
		bump[CNT_TOTAL] = exec_s1;
		unique case (opc) inside
			[OPC_ADD:OPC_INC]:   bump[CNT_ARITH] = exec_s1;
			[OPC_AND:OPC_XOR]:   bump[CNT_LOGIC] = exec_s1;
			OPC_LOAD, OPC_STORE: bump[CNT_DATA]  = exec_s1;
			OPC_JMP, OPC_BEQZ:   bump[CNT_CTRL]  = exec_s1;
			OPC_HALT:            bump[CNT_HALT]  = exec_s1;
			default:             bump            = bump;
		endcase
	end

	assign sum_ab    = rf_q.a + rf_q.b;
	assign mem_addr  = (op_s1 == OP_EXEC) ? MOD_TBL[sum_ab] : MOD_TBL[addr_s1];
	assign mem_we    = (op_s1 == OP_WR_MEM) || (exec_s1 && opc == OPC_STORE);
	assign mem_re    = (op_s1 == OP_RD_MEM) || (exec_s1 && opc == OPC_LOAD);
	assign mem_wdata = (op_s1 == OP_EXEC) ? rf_q.c : data_s1;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			if (mem_we) begin
				dmem[mem_addr] <= mem_wdata;
			end
			if (mem_re) begin
				mem_rd_s2 <= dmem[mem_addr];
			end
		end
	end

	assign pc_plus2  = pc_q + 16'd2;
	assign br_off    = (opc == OPC_JMP) ? instr_s1[11:4] : instr_s1[7:0];
	assign br_target = pc_plus2 + {{7{br_off[7]}}, br_off, 1'b0};

	always_comb begin
		npc = pc_plus2;
		if (opc == OPC_JMP || (opc == OPC_BEQZ && rf_q.c == 8'd0)) begin
			npc = br_target;
		end
	end

	assign pc_new   = exec_s1 ? npc : pc_q;
	assign halt_new = halt_q || (exec_s1 && opc == OPC_HALT);

	always_comb begin
		rdata = 32'd0;
		unique case (op_s1)
			OP_RD_CNT: begin
				if (index_s1 < 4'(NUM_CNT)) begin
					rdata = cnt_q[index_s1[CIDX_W-1:0]];
				end
			end
			OP_RD_REG: rdata = {24'd0, rf_q.a};
			default:   rdata = 32'd0;
		endcase
	end

	always_comb begin
		rf_wr = '0;
		if (wb_pend_q) begin
			rf_wr.en   = 1'b1;
			rf_wr.addr = rd_s2;
			rf_wr.data = mem_rd_s2;
		end else if (s1_adv && op_s1 == OP_WR_REG) begin
			rf_wr.en   = 1'b1;
			rf_wr.addr = index_s1;
			rf_wr.data = data_s1;
		end else if (s1_adv && exec_s1 && alu_wr) begin
			rf_wr.en   = 1'b1;
			rf_wr.addr = instr_s1[11:8];
			rf_wr.data = alu_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= 16'd0;
			halt_q    <= 1'b0;
			wb_pend_q <= 1'b0;
			for (int k = 0; k < NUM_CNT; k++) begin
				cnt_q[k] <= 32'd0;
			end
		end else begin
			wb_pend_q <= s1_adv && load_s1;
			if (s1_adv) begin
				pc_q   <= pc_new;
				halt_q <= halt_new;
				for (int k = 0; k < NUM_CNT; k++) begin
					if (bump[k] && cnt_q[k] != 32'hFFFF_FFFF) begin
						cnt_q[k] <= cnt_q[k] + 32'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			next_pc_s2  <= pc_new;
			halted_s2   <= halt_new;
			executed_s2 <= exec_s1;
			rdata_s2    <= rdata;
			rmem_s2     <= (op_s1 == OP_RD_MEM);
			rd_s2       <= instr_s1[11:8];
		end
	end

	assign out_valid = valid_s2;
	assign next_pc   = next_pc_s2;
	assign halted    = halted_s2;
	assign executed  = executed_s2;
	assign read_data = rmem_s2 ? {24'd0, mem_rd_s2} : rdata_s2;

endmodule

// ===== rtl/core/ebrc_checker.sv =====
// ----------------------------------------------------------------------------
// ebrc_checker
// Port-level checks of the core's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "eight_bit_risc_core_unit_defines.svh"

module ebrc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] next_pc,
	input logic        halted,
	input logic        executed,
	input logic [31:0] read_data
);

	logic seen_halt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_halt_q <= 1'b0;
		end else if (out_valid && out_ready && halted) begin
			seen_halt_q <= 1'b1;
		end
	end

	`EBRC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`EBRC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(next_pc) && $stable(halted) && $stable(executed) && $stable(read_data), "result changed while stalled")
	`EBRC_ASSERT_IMPLIES(a_halt_sticky, out_valid && seen_halt_q, halted, "halt flag cleared")
	`EBRC_ASSERT_IMPLIES(a_no_exec_halted, out_valid && seen_halt_q, !executed, "transaction executed after halt")

endmodule

bind eight_bit_risc_core_unit ebrc_checker u_ebrc_checker (.*);

// ===== dv/tb_eight_bit_risc_core_unit.sv =====
// ----------------------------------------------------------------------------
// tb_eight_bit_risc_core_unit
// Self-checking bench for the 8-bit RISC core: a short directed table covers
// every opcode but HALT, host op and corner (wrap, branch extremes, idle ops,
// counter index above range), then constrained-legal random traffic runs the
// core through a late HALT. Every result is scoreboarded against its table
// row or a bench-side core model, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_eight_bit_risc_core_unit import ebrc_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam op_t  OP_SPARE_A  = 3'd6;
	localparam op_t  OP_SPARE_B  = 3'd7;
	localparam opc_t OPC_NOP_LO  = 4'd12;
	localparam int   DIR_N       = 27;
	localparam int   RAND_N      = 1600;
	localparam int   HALT_AT     = RAND_N - 80;
	localparam int   CALM_TAIL   = 250;
	localparam int   CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [15:0] next_pc;
		logic        halted;
		logic        executed;
		logic [31:0] read_data;
	} core_result_t;

	typedef struct packed {
		op_t          op;
		logic [15:0]  instr;
		logic [7:0]   addr;
		logic [3:0]   index;
		logic [7:0]   data;
		logic         typed;
		core_result_t want;
	} stim_row_t;

	localparam core_result_t IDLE_RESULT = '0;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  op;
	logic [15:0] instr;
	logic [7:0]  addr;
	logic [3:0]  index;
	logic [7:0]  data;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] next_pc;
	logic        halted;
	logic        executed;
	logic [31:0] read_data;

	logic [15:0] pc_q;
	logic        halt_q;
	logic [7:0]  regs [REG_COUNT];
	logic [7:0]  dmem [DATA_DEPTH_DEF];
	logic [31:0] class_cnt [NUM_CNT];
	bit          reg_set [REG_COUNT];
	bit          mem_set [DATA_DEPTH_DEF];

	core_result_t core_results_due [$];
	int           mismatches;
	int           cycle_count;
	int           idle_pct;
	int           stall_left;

	eight_bit_risc_core_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.instr     (instr),
		.addr      (addr),
		.index     (index),
		.data      (data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.next_pc   (next_pc),
		.halted    (halted),
		.executed  (executed),
		.read_data (read_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void bump_class(cidx_t k);
		if (class_cnt[k] != 32'hFFFF_FFFF)
			class_cnt[k] = class_cnt[k] + 32'd1;
	endfunction

	function automatic logic [15:0] branch_dest(logic [7:0] off);
		return pc_q + 16'd2 + {{7{off[7]}}, off, 1'b0};
	endfunction

	task automatic advance_core(input op_t cop, input logic [15:0] word,
			input logic [7:0] baddr, input logic [3:0] sel, input logic [7:0] wdata,
			output core_result_t res);
		opc_t        opc;
		logic [3:0]  rd;
		logic [7:0]  va;
		logic [7:0]  vb;
		logic [7:0]  ea;
		logic [15:0] npc;
		res = '0;
		opc = word[15:12];
		rd  = word[11:8];
		va  = regs[word[7:4]];
		vb  = regs[word[3:0]];
		ea  = va + vb;
		case (cop)
			OP_EXEC: begin
				if (!halt_q) begin
					npc = pc_q + 16'd2;
					bump_class(CNT_TOTAL);
					case (opc)
						OPC_ADD: begin regs[rd] = va + vb; bump_class(CNT_ARITH); end
						OPC_SUB: begin regs[rd] = va - vb; bump_class(CNT_ARITH); end
						OPC_MUL: begin regs[rd] = va * vb; bump_class(CNT_ARITH); end
						OPC_INC: begin regs[rd] = regs[rd] + 8'd1; bump_class(CNT_ARITH); end
						OPC_AND: begin regs[rd] = va & vb; bump_class(CNT_LOGIC); end
						OPC_OR:  begin regs[rd] = va | vb; bump_class(CNT_LOGIC); end
						OPC_NOT: begin regs[rd] = ~va; bump_class(CNT_LOGIC); end
						OPC_XOR: begin regs[rd] = va ^ vb; bump_class(CNT_LOGIC); end
						OPC_LOAD: begin
							regs[rd] = dmem[ea % DATA_DEPTH_DEF];
							bump_class(CNT_DATA);
						end
						OPC_STORE: begin
							dmem[ea % DATA_DEPTH_DEF] = regs[rd];
							mem_set[ea % DATA_DEPTH_DEF] = 1'b1;
							bump_class(CNT_DATA);
						end
						OPC_JMP: begin
							npc = branch_dest(word[11:4]);
							bump_class(CNT_CTRL);
						end
						OPC_BEQZ: begin
							if (regs[rd] == 8'd0)
								npc = branch_dest(word[7:0]);
							bump_class(CNT_CTRL);
						end
						OPC_HALT: begin
							halt_q = 1'b1;
							bump_class(CNT_HALT);
						end
						default: ;
					endcase
					if (opc <= OPC_LOAD)
						reg_set[rd] = 1'b1;
					pc_q = npc;
					res.executed = 1'b1;
				end
			end
			OP_WR_REG: begin
				regs[sel] = wdata;
				reg_set[sel] = 1'b1;
			end
			OP_WR_MEM: begin
				dmem[baddr % DATA_DEPTH_DEF] = wdata;
				mem_set[baddr % DATA_DEPTH_DEF] = 1'b1;
			end
			OP_RD_MEM: res.read_data = {24'd0, dmem[baddr % DATA_DEPTH_DEF]};
			OP_RD_CNT: res.read_data = (sel < NUM_CNT) ? class_cnt[sel[CIDX_W-1:0]] : 32'd0;
			OP_RD_REG: res.read_data = {24'd0, regs[sel]};
			default: ;
		endcase
		res.next_pc = pc_q;
		res.halted  = halt_q;
	endtask

	task automatic send_item(input stim_row_t row);
		core_result_t predicted;
		int           gap;
		@(negedge clk);
		in_valid <= 1'b1;
		op       <= row.op;
		instr    <= row.instr;
		addr     <= row.addr;
		index    <= row.index;
		data     <= row.data;
		do @(posedge clk); while (!in_ready);
		advance_core(row.op, row.instr, row.addr, row.index, row.data, predicted);
		core_results_due.push_back(row.typed ? row.want : predicted);
		if ($urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 11);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	function automatic void match_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t %s expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		core_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (core_results_due.size() == 0) begin
				$display("%0t unexpected transaction expected none actual pc %0h rd %0h",
					$time, next_pc, read_data);
				mismatches++;
			end else begin
				want = core_results_due.pop_front();
				match_field("next_pc", 32'(want.next_pc), 32'(next_pc));
				match_field("halted", 32'(want.halted), 32'(halted));
				match_field("executed", 32'(want.executed), 32'(executed));
				match_field("read_data", want.read_data, read_data);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		out_ready  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				stall_left = $urandom_range(1, 11) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		stim_row_t directed [DIR_N];
		stim_row_t row;
		int        pick;
		logic [7:0] ea;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		op          = OP_EXEC;
		instr       = 16'd0;
		addr        = 8'd0;
		index       = 4'd0;
		data        = 8'd0;
		mismatches  = 0;
		cycle_count = 0;
		idle_pct    = 20;
		pc_q        = 16'd0;
		halt_q      = 1'b0;
		for (int i = 0; i < REG_COUNT; i++) begin
			regs[i] = 8'd0;
			reg_set[i] = 1'b0;
		end
		for (int i = 0; i < DATA_DEPTH_DEF; i++) begin
			dmem[i] = 8'd0;
			mem_set[i] = 1'b0;
		end
		for (int i = 0; i < NUM_CNT; i++)
			class_cnt[i] = 32'd0;

		directed = '{
			'{OP_RD_CNT, 16'h0000, 8'h00, {1'b0, CNT_TOTAL}, 8'h00, 1'b1, IDLE_RESULT},
			'{OP_RD_CNT, 16'h0000, 8'h00, 4'hF, 8'h00, 1'b1, IDLE_RESULT},
			'{OP_SPARE_A, 16'hFFFF, 8'hFF, 4'hF, 8'hFF, 1'b1, IDLE_RESULT},
			'{OP_WR_REG, 16'h0000, 8'h00, 4'd0, 8'hFF, 1'b1, IDLE_RESULT},
			'{OP_WR_REG, 16'h0000, 8'h00, 4'd1, 8'h01, 1'b1, IDLE_RESULT},
			'{OP_WR_REG, 16'h0000, 8'h00, 4'd2, 8'h00, 1'b1, IDLE_RESULT},
			'{OP_WR_REG, 16'h0000, 8'h00, 4'd15, 8'h80, 1'b1, IDLE_RESULT},
			'{OP_WR_MEM, 16'h0000, 8'hFF, 4'd0, 8'hA5, 1'b1, IDLE_RESULT},
			'{OP_WR_MEM, 16'h0000, 8'h00, 4'd0, 8'h5A, 1'b1, IDLE_RESULT},
			'{OP_RD_MEM, 16'h0000, 8'hFF, 4'd0, 8'h00, 1'b1,
				'{16'h0000, 1'b0, 1'b0, 32'h0000_00A5}},
			'{OP_RD_REG, 16'h0000, 8'h00, 4'd15, 8'h00, 1'b1,
				'{16'h0000, 1'b0, 1'b0, 32'h0000_0080}},
			'{OP_EXEC, {OPC_ADD, 4'd3, 4'd0, 4'd1}, 8'h00, 4'd0, 8'h00, 1'b0, IDLE_RESULT},
			'{OP_EXEC, {OPC_SUB, 4'd4, 4'd2, 4'd1}, 8'h00, 4'd0, 8'h00, 1'b0, IDLE_RESULT},
			'{OP_EXEC, {OPC_MUL, 4'd5, 4'd0, 4'd0}, 8'h00, 4'd0, 8'h00, 1'b0, IDLE_RESULT},
			'{OP_EXEC, {OPC_INC, 4'd0, 4'd0, 4'd0}, 8'h00, 4'd0, 8'h00, 1'b0, IDLE_RESULT},
			'{OP_EXEC, {OPC_AND, 4'd6, 4'd15, 4'd0}, 8'h00, 4'd0, 8'h00, 1'b0, IDLE_RESULT},
			'{OP_EXEC, {OPC_OR, 4'd7, 4'd15, 4'd1}, 8'h00, 4'd0, 8'h00, 1'b0, IDLE_RESULT},
			'{OP_EXEC, {OPC_NOT, 4'd8, 4'd2, 4'd1}, 8'h00, 4'd0, 8'h00, 1'b0, IDLE_RESULT},
			'{OP_EXEC, {OPC_XOR, 4'd9, 4'd15, 4'd4}, 8'h00, 4'd0, 8'h00, 1'b0, IDLE_RESULT},
			'{OP_EXEC, {OPC_LOAD, 4'd10, 4'd0, 4'd2}, 8'h00, 4'd0, 8'h00, 1'b0, IDLE_RESULT},
			'{OP_EXEC, {OPC_STORE, 4'd15, 4'd4, 4'd1}, 8'h00, 4'd0, 8'h00, 1'b0, IDLE_RESULT},
			'{OP_EXEC, {OPC_JMP, 8'h80, 4'd0}, 8'h00, 4'd0, 8'h00, 1'b0, IDLE_RESULT},
			'{OP_EXEC, {OPC_BEQZ, 4'd2, 8'hFF}, 8'h00, 4'd0, 8'h00, 1'b0, IDLE_RESULT},
			'{OP_EXEC, {OPC_BEQZ, 4'd1, 8'h10}, 8'h00, 4'd0, 8'h00, 1'b0, IDLE_RESULT},
			'{OP_EXEC, {OPC_NOP_LO, 12'hFFF}, 8'h00, 4'd0, 8'h00, 1'b0, IDLE_RESULT},
			'{OP_RD_MEM, 16'h0000, 8'h00, 4'd0, 8'h00, 1'b0, IDLE_RESULT},
			'{OP_RD_CNT, 16'h0000, 8'h00, {1'b0, CNT_ARITH}, 8'h00, 1'b0, IDLE_RESULT}
		};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_N; i++)
			send_item(directed[i]);

		for (int i = 0; i < RAND_N; i++) begin
			if (i % 128 == 0) begin
				case ((i / 128) % 3)
					0: idle_pct = 0;
					1: idle_pct = 12;
					default: idle_pct = 35;
				endcase
			end
			if (i >= RAND_N - CALM_TAIL)
				idle_pct = 0;
			if (i == RAND_N / 2) begin
				@(negedge clk);
				in_valid <= 1'b0;
				while (core_results_due.size() != 0) @(negedge clk);
			end

			row       = '0;
			row.instr = 16'($urandom);
			row.addr  = 8'($urandom);
			row.index = 4'($urandom);
			row.data  = 8'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 58)      row.op = OP_EXEC;
			else if (pick < 68) row.op = OP_WR_REG;
			else if (pick < 78) row.op = OP_WR_MEM;
			else if (pick < 85) row.op = OP_RD_MEM;
			else if (pick < 91) row.op = OP_RD_CNT;
			else if (pick < 97) row.op = OP_RD_REG;
			else if (pick < 98) row.op = OP_SPARE_A;
			else                row.op = OP_SPARE_B;

			// hold HALT back until the tail so the core keeps running
			if (i < HALT_AT && row.instr[15:12] == OPC_HALT)
				row.instr[15:12] = 4'($urandom_range(0, 14));
			if (i == HALT_AT) begin
				row.op = OP_EXEC;
				row.instr[15:12] = OPC_HALT;
			end

			// replace reads of unwritten storage with a write to it
			if (row.op == OP_RD_REG && !reg_set[row.index])
				row.op = OP_WR_REG;
			if (row.op == OP_RD_MEM && !mem_set[row.addr])
				row.op = OP_WR_MEM;
			if (row.op == OP_EXEC && !halt_q && row.instr[15:12] <= OPC_BEQZ) begin
				ea = regs[row.instr[7:4]] + regs[row.instr[3:0]];
				if (!reg_set[row.instr[11:8]]) begin
					row.op = OP_WR_REG;
					row.index = row.instr[11:8];
				end else if (!reg_set[row.instr[7:4]]) begin
					row.op = OP_WR_REG;
					row.index = row.instr[7:4];
				end else if (!reg_set[row.instr[3:0]]) begin
					row.op = OP_WR_REG;
					row.index = row.instr[3:0];
				end else if (row.instr[15:12] == OPC_LOAD && !mem_set[ea]) begin
					row.op = OP_WR_MEM;
					row.addr = ea;
				end
			end
			send_item(row);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (core_results_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ebrc_pkg.sv
rtl/core/ebrc_regfile.sv
rtl/core/eight_bit_risc_core_unit.sv
rtl/core/ebrc_checker.sv
dv/tb_eight_bit_risc_core_unit.sv
